/* hdl/cge_pkg.sv */
// ----------------------------------------------------------------------------
// cge_pkg: shared types and codes of the crowd grid evacuation step
// Cell codes, item modes, register indexes and the neighborhood and move
// records passed between the sequencer and the move chooser.
// ----------------------------------------------------------------------------
package cge_pkg;

    typedef logic [1:0] t_cell;

    // A cell holding the claim code is empty and reserved for this tick.
    localparam t_cell CELL_EMPTY  = 2'd0;
    localparam t_cell CELL_WALL   = 2'd1;
    localparam t_cell CELL_PERSON = 2'd2;
    localparam t_cell CELL_CLAIM  = 2'd3;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [1:0] CFG_EXIT_COL = 2'd0;
    localparam logic [1:0] CFG_PEOPLE   = 2'd1;
    localparam logic [1:0] CFG_SEED     = 2'd2;

    localparam logic [6:0]  EXIT_COL_RST = 7'd63;
    localparam logic [11:0] PEOPLE_RST   = 12'd0;
    localparam logic [15:0] SEED_RST     = 16'd1;
    localparam logic [15:0] LFSR_MASK    = 16'hB400;
    localparam logic [11:0] EXIT_MAX     = 12'hFFF;

    typedef struct packed {
        t_cell up;
        t_cell here;
        t_cell down;
        t_cell right;
        logic  has_up;
        logic  has_down;
        logic  has_right;
        logic  exit_hit;
        logic  rand_bit;
    } t_nbr;

    typedef struct packed {
        logic  go_right;
        logic  leave;
        logic  use_rand;
        t_cell up;
        t_cell here;
        t_cell down;
    } t_move;

endpackage

/* hdl/cge_ram.sv */
// ----------------------------------------------------------------------------
// cge_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cge_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/cge_lfsr.sv */
// ----------------------------------------------------------------------------
// cge_lfsr: random bit source
// 16-bit Galois LFSR shifting right; a zero seed loads as one.
// ----------------------------------------------------------------------------
module cge_lfsr (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [15:0] i_seed,
    input  logic        i_step,
    output logic        o_bit
);

    logic [15:0] r_lfsr;
    logic [15:0] n_lfsr;

    always_comb begin
        n_lfsr = r_lfsr;
        if (i_load) begin
            n_lfsr = (i_seed == 16'd0) ? 16'd1 : i_seed;
        end else if (i_step) begin
            n_lfsr = (r_lfsr >> 1) ^ (r_lfsr[0] ? cge_pkg::LFSR_MASK : 16'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= cge_pkg::SEED_RST;
        end else begin
            r_lfsr <= n_lfsr;
        end
    end

    assign o_bit = r_lfsr[0];

endmodule

/* hdl/cge_move.sv */
// ----------------------------------------------------------------------------
// cge_move: move chooser for one person
// Picks right, random up/down, down or up, and returns the updated window.
// ----------------------------------------------------------------------------
module cge_move (
    input  cge_pkg::t_nbr  i_nbr,
    output cge_pkg::t_move o_move
);

    logic right_ok;
    logic down_ok;
    logic up_ok;

    assign right_ok = i_nbr.has_right && (i_nbr.right == cge_pkg::CELL_EMPTY);
    assign down_ok  = i_nbr.has_down && (i_nbr.down == cge_pkg::CELL_EMPTY);
    assign up_ok    = i_nbr.has_up && (i_nbr.up == cge_pkg::CELL_EMPTY);

    always_comb begin
        o_move.go_right = 1'b0;
        o_move.leave    = 1'b0;
        o_move.use_rand = 1'b0;
        o_move.up       = i_nbr.up;
        o_move.here     = i_nbr.here;
        o_move.down     = i_nbr.down;
        if (i_nbr.here == cge_pkg::CELL_PERSON) begin
            if (right_ok) begin
                o_move.go_right = 1'b1;
                o_move.leave    = i_nbr.exit_hit;
                o_move.here     = cge_pkg::CELL_EMPTY;
            end else if (down_ok && up_ok) begin
                o_move.use_rand = 1'b1;
                o_move.here     = cge_pkg::CELL_EMPTY;
                if (i_nbr.rand_bit) begin
                    o_move.down = cge_pkg::CELL_CLAIM;
                end else begin
                    o_move.up = cge_pkg::CELL_CLAIM;
                end
            end else if (down_ok) begin
                o_move.here = cge_pkg::CELL_EMPTY;
                o_move.down = cge_pkg::CELL_CLAIM;
            end else if (up_ok) begin
                o_move.here = cge_pkg::CELL_EMPTY;
                o_move.up   = cge_pkg::CELL_CLAIM;
            end
        end
    end

endmodule

/* hdl/crowd_grid_evacuation_step.sv */
// ----------------------------------------------------------------------------
// crowd_grid_evacuation_step: crowd evacuation on a grid of cells
// Cell write, cell read and tick items over a grid held in one RAM.
// ----------------------------------------------------------------------------
// The grid lives in one 2-bit RAM addressed {row, col}; a claimed empty cell
// holds a fourth code until the tick ends. After reset a clearing pass writes
// every RAM entry, and no item is taken until it ends; configuration writes
// are taken at any time. A write item goes straight to the result state; a
// read item first waits for the RAM data. A tick scans each column through a
// three-row window: it loads the window, reads per row the cell below and the
// cell to the right on the RAM's single read port, and writes the window
// back; then one commit sweep of one RAM entry per cycle turns claims into
// people. A tick once the room is finished only counts the tick. Items go
// one at a time; a new item is taken while the previous result waits in the
// output register.
// ----------------------------------------------------------------------------
module crowd_grid_evacuation_step #(
    parameter int GRID_ROWS = 32,
    parameter int GRID_COLS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [4:0]  i_row,
    input  logic [5:0]  i_col,
    input  logic [1:0]  i_cell_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_read_value,
    output logic [11:0] o_people_left,
    output logic [31:0] o_tick_count,
    output logic        o_finished
);

    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CW    = $clog2(GRID_COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int XW    = (CW >= 7) ? CW + 1 : 7;

    localparam logic [RW-1:0] ROW_LAST = RW'(GRID_ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(GRID_COLS - 1);

    localparam logic [3:0] ST_CLEAR      = 4'd0;
    localparam logic [3:0] ST_IDLE       = 4'd1;
    localparam logic [3:0] ST_RDWAIT     = 4'd2;
    localparam logic [3:0] ST_LD_HERE    = 4'd3;
    localparam logic [3:0] ST_LD_DOWN    = 4'd4;
    localparam logic [3:0] ST_RIGHT      = 4'd5;
    localparam logic [3:0] ST_DECIDE     = 4'd6;
    localparam logic [3:0] ST_FLUSH_A    = 4'd7;
    localparam logic [3:0] ST_FLUSH_B    = 4'd8;
    localparam logic [3:0] ST_COMMIT     = 4'd9;
    localparam logic [3:0] ST_COMMIT_END = 4'd10;
    localparam logic [3:0] ST_DONE       = 4'd11;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                 input logic [CW-1:0] c);
        return {r, c};
    endfunction

    logic [3:0]         r_state, n_state;
    logic [RW-1:0]      r_row, n_row;
    logic [CW-1:0]      r_col, n_col;
    cge_pkg::t_cell     r_up, n_up;
    cge_pkg::t_cell     r_here, n_here;
    cge_pkg::t_cell     r_down, n_down;
    cge_pkg::t_cell     r_ev_val, n_ev_val;
    logic [RW-1:0]      r_ev_row, n_ev_row;
    logic               r_ev_pend, n_ev_pend;
    logic [AW-1:0]      r_sweep, n_sweep;
    logic [AW-1:0]      r_cm_addr, n_cm_addr;
    logic               r_cm_pend, n_cm_pend;
    logic               r_rd_inside, n_rd_inside;
    cge_pkg::t_cell     r_rd_val, n_rd_val;
    logic [11:0]        r_exited, n_exited;
    logic [31:0]        r_ticks, n_ticks;
    logic [6:0]         r_exit_col, n_exit_col;
    logic [11:0]        r_people_total, n_people_total;
    logic               r_out_valid, n_out_valid;
    cge_pkg::t_cell     r_out_read, n_out_read;
    logic [11:0]        r_out_left, n_out_left;
    logic [31:0]        r_out_ticks, n_out_ticks;
    logic               r_out_fin, n_out_fin;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    cge_pkg::t_cell     ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    cge_pkg::t_cell     ram_rdata;

    logic               in_acc;
    logic               cfg_acc;
    logic               in_grid;
    logic               done_now;
    logic               lfsr_bit;
    logic               lfsr_step;
    cge_pkg::t_nbr      nbr;
    cge_pkg::t_move     mv;

    cge_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cge_lfsr u_lfsr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (cfg_acc && (i_cfg_index == cge_pkg::CFG_SEED)),
        .i_seed  (i_cfg_data),
        .i_step  (lfsr_step),
        .o_bit   (lfsr_bit)
    );

    assign nbr.up        = r_up;
    assign nbr.here      = r_here;
    assign nbr.down      = r_down;
    assign nbr.right     = ram_rdata;
    assign nbr.has_up    = (r_row != '0);
    assign nbr.has_down  = (r_row != ROW_LAST);
    assign nbr.has_right = (r_col != COL_LAST);
    assign nbr.exit_hit  = (XW'(r_col) + XW'(1)) >= XW'(r_exit_col);
    assign nbr.rand_bit  = lfsr_bit;

    cge_move u_move (
        .i_nbr  (nbr),
        .o_move (mv)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign in_grid     = (32'(i_row) < 32'(GRID_ROWS)) && (32'(i_col) < 32'(GRID_COLS));
    assign done_now    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state        = r_state;
        n_row          = r_row;
        n_col          = r_col;
        n_up           = r_up;
        n_here         = r_here;
        n_down         = r_down;
        n_ev_val       = r_ev_val;
        n_ev_row       = r_ev_row;
        n_ev_pend      = r_ev_pend;
        n_sweep        = r_sweep;
        n_cm_addr      = r_cm_addr;
        n_cm_pend      = r_cm_pend;
        n_rd_inside    = r_rd_inside;
        n_rd_val       = r_rd_val;
        n_exited       = r_exited;
        n_ticks        = r_ticks;
        n_exit_col     = r_exit_col;
        n_people_total = r_people_total;
        n_out_valid    = r_out_valid;
        n_out_read     = r_out_read;
        n_out_left     = r_out_left;
        n_out_ticks    = r_out_ticks;
        n_out_fin      = r_out_fin;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = cge_pkg::CELL_EMPTY;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        lfsr_step      = 1'b0;

        if (cfg_acc) begin
            case (i_cfg_index)
                cge_pkg::CFG_EXIT_COL: n_exit_col = i_cfg_data[6:0];
                cge_pkg::CFG_PEOPLE:   n_people_total = i_cfg_data[11:0];
                default: ;
            endcase
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep;
                ram_wdata = cge_pkg::CELL_EMPTY;
                n_sweep   = r_sweep + AW'(1);
                if (r_sweep == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_rd_val = cge_pkg::CELL_EMPTY;
                    n_state  = ST_DONE;
                    case (i_mode)
                        cge_pkg::MODE_WRITE: begin
                            if (in_grid && (i_cell_value != cge_pkg::CELL_CLAIM)) begin
                                ram_we    = 1'b1;
                                ram_waddr = cell_addr(RW'(i_row), CW'(i_col));
                                ram_wdata = i_cell_value;
                            end
                        end
                        cge_pkg::MODE_READ: begin
                            ram_re      = 1'b1;
                            ram_raddr   = cell_addr(RW'(i_row), CW'(i_col));
                            n_rd_inside = in_grid;
                            n_state     = ST_RDWAIT;
                        end
                        cge_pkg::MODE_TICK: begin
                            if (r_exited >= r_people_total) begin
                                n_ticks = r_ticks + 32'd1;
                            end else begin
                                n_row     = '0;
                                n_col     = '0;
                                n_ev_pend = 1'b0;
                                n_state   = ST_LD_HERE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RDWAIT: begin
                n_rd_val = r_rd_inside ? ram_rdata : cge_pkg::CELL_EMPTY;
                n_state  = ST_DONE;
            end
            ST_LD_HERE: begin
                ram_re    = 1'b1;
                ram_raddr = cell_addr(r_row, r_col);
                n_state   = ST_LD_DOWN;
            end
            ST_LD_DOWN: begin
                n_here    = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = cell_addr(r_row + RW'(1), r_col);
                n_state   = ST_RIGHT;
            end
            ST_RIGHT: begin
                n_down = (r_row != ROW_LAST) ? ram_rdata : cge_pkg::CELL_WALL;
                if (r_col != COL_LAST) begin
                    ram_re    = 1'b1;
                    ram_raddr = cell_addr(r_row, r_col + CW'(1));
                end
                if (r_ev_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = cell_addr(r_ev_row, r_col);
                    ram_wdata = r_ev_val;
                    n_ev_pend = 1'b0;
                end
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                lfsr_step = mv.use_rand;
                if (mv.go_right && !mv.leave) begin
                    ram_we    = 1'b1;
                    ram_waddr = cell_addr(r_row, r_col + CW'(1));
                    ram_wdata = cge_pkg::CELL_CLAIM;
                end
                if (mv.leave && (r_exited != cge_pkg::EXIT_MAX)) begin
                    n_exited = r_exited + 12'd1;
                end
                if (r_row != ROW_LAST) begin
                    if ((r_row + RW'(1)) != ROW_LAST) begin
                        ram_re    = 1'b1;
                        ram_raddr = cell_addr(r_row + RW'(2), r_col);
                    end
                    n_up      = mv.here;
                    n_here    = mv.down;
                    n_ev_val  = mv.up;
                    n_ev_row  = r_row - RW'(1);
                    n_ev_pend = (r_row != '0);
                    n_row     = r_row + RW'(1);
                    n_state   = ST_RIGHT;
                end else begin
                    n_up    = mv.up;
                    n_here  = mv.here;
                    n_state = ST_FLUSH_A;
                end
            end
            ST_FLUSH_A: begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(ROW_LAST - RW'(1), r_col);
                ram_wdata = r_up;
                n_state   = ST_FLUSH_B;
            end
            ST_FLUSH_B: begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(ROW_LAST, r_col);
                ram_wdata = r_here;
                n_row     = '0;
                if (r_col == COL_LAST) begin
                    n_sweep   = '0;
                    n_cm_pend = 1'b0;
                    n_state   = ST_COMMIT;
                end else begin
                    n_col   = r_col + CW'(1);
                    n_state = ST_LD_HERE;
                end
            end
            ST_COMMIT: begin
                ram_re    = 1'b1;
                ram_raddr = r_sweep;
                if (r_cm_pend && (ram_rdata == cge_pkg::CELL_CLAIM)) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cm_addr;
                    ram_wdata = cge_pkg::CELL_PERSON;
                end
                n_cm_addr = r_sweep;
                n_cm_pend = 1'b1;
                n_sweep   = r_sweep + AW'(1);
                if (r_sweep == '1) begin
                    n_state = ST_COMMIT_END;
                end
            end
            ST_COMMIT_END: begin
                if (ram_rdata == cge_pkg::CELL_CLAIM) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cm_addr;
                    ram_wdata = cge_pkg::CELL_PERSON;
                end
                n_cm_pend = 1'b0;
                n_ticks   = r_ticks + 32'd1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (done_now) begin
                    n_out_valid = 1'b1;
                    n_out_read  = r_rd_val;
                    n_out_left  = r_exited;
                    n_out_ticks = r_ticks;
                    n_out_fin   = (r_exited >= r_people_total);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_sweep        <= '0;
            r_ev_pend      <= 1'b0;
            r_cm_pend      <= 1'b0;
            r_exited       <= '0;
            r_ticks        <= '0;
            r_exit_col     <= cge_pkg::EXIT_COL_RST;
            r_people_total <= cge_pkg::PEOPLE_RST;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_sweep        <= n_sweep;
            r_ev_pend      <= n_ev_pend;
            r_cm_pend      <= n_cm_pend;
            r_exited       <= n_exited;
            r_ticks        <= n_ticks;
            r_exit_col     <= n_exit_col;
            r_people_total <= n_people_total;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row       <= n_row;
        r_col       <= n_col;
        r_up        <= n_up;
        r_here      <= n_here;
        r_down      <= n_down;
        r_ev_val    <= n_ev_val;
        r_ev_row    <= n_ev_row;
        r_cm_addr   <= n_cm_addr;
        r_rd_inside <= n_rd_inside;
        r_rd_val    <= n_rd_val;
        r_out_read  <= n_out_read;
        r_out_left  <= n_out_left;
        r_out_ticks <= n_out_ticks;
        r_out_fin   <= n_out_fin;
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out_read;
    assign o_people_left = r_out_left;
    assign o_tick_count  = r_out_ticks;
    assign o_finished    = r_out_fin;

    a_exited_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_exited >= $past(r_exited)))
        else $error("exit count went down");

    a_claim_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (ram_wdata == cge_pkg::CELL_CLAIM)) |->
            ((r_state == ST_RIGHT) || (r_state == ST_DECIDE) ||
             (r_state == ST_FLUSH_A) || (r_state == ST_FLUSH_B)))
        else $error("claim code written outside the scan");

    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write of one entry in one cycle");

    a_read_no_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDWAIT) |-> (ram_rdata != cge_pkg::CELL_CLAIM))
        else $error("claim code left in the grid after a tick");

endmodule
